@@ rtl/sha1md_pkg.sv @@
// shared constants and types for the sha-1 message digest block
// used by sha1md_ctrl, sha1md_dp and sha1_message_digest; no dependencies
package sha1md_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned CNT_W = 7;
	localparam int unsigned FILL_W = 6;
	localparam int unsigned WORDS = 5;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [FILL_W-1:0] LEN_POS = 6'd56;

	// byte source select
	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_MARK = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	// round group select
	localparam logic [1:0] GRP_CH  = 2'd0;
	localparam logic [1:0] GRP_P1  = 2'd1;
	localparam logic [1:0] GRP_MAJ = 2'd2;
	localparam logic [1:0] GRP_P2  = 2'd3;

	typedef struct packed {
		logic       push;
		logic [1:0] sel;
		logic       count;
		logic       start_block;
		logic       round;
		logic [1:0] grp;
		logic       add;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_len;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/sha1_message_digest.sv @@
// Streaming SHA-1 engine. Input transfers are accepted only while the
// controller is idle; the transfer that completes a 64-byte block starts a
// compression (80 rounds on one shared round unit, then the chaining add). A
// transfer with last then pushes one padding byte per cycle (9 to 72 bytes)
// and runs one or two more compressions, then the digest is loaded and
// the five digest words leave one per accepted output transfer.
// The next message is accepted while the digest words are still draining.
// top level; depends on sha1md_pkg, sha1md_ctrl and sha1md_dp
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha1md_pkg::cmd_t cmd;
	sha1md_pkg::sts_t sts;

	sha1md_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.has_byte (has_byte),
		.last     (last),
		.sts      (sts),
		.cmd      (cmd)
	);

	sha1md_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

@@ rtl/sha1md_ctrl.sv @@
// controller for the sha-1 message digest block: input handshake, padding
// sequence and round sequencing; depends on sha1md_pkg
module sha1md_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               has_byte,
	input  logic               last,
	input  sha1md_pkg::sts_t   sts,
	output sha1md_pkg::cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PAD   = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [1:0] PH_MARK = 2'd0;
	localparam logic [1:0] PH_ZERO = 2'd1;
	localparam logic [1:0] PH_LEN  = 2'd2;

	logic [2:0]                       state_q;
	logic [1:0]                       phase_q;
	logic                             last_q;
	logic                             padding_q;
	logic [sha1md_pkg::CNT_W-1:0]     round_q;
	logic                             accept;

	assign accept = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		if (round_q < sha1md_pkg::CNT_W'(20))
			cmd.grp = sha1md_pkg::GRP_CH;
		else if (round_q < sha1md_pkg::CNT_W'(40))
			cmd.grp = sha1md_pkg::GRP_P1;
		else if (round_q < sha1md_pkg::CNT_W'(60))
			cmd.grp = sha1md_pkg::GRP_MAJ;
		else
			cmd.grp = sha1md_pkg::GRP_P2;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.sel = sha1md_pkg::SEL_DATA;
				if (in_valid) begin
					cmd.push = has_byte;
					cmd.count = has_byte;
					cmd.start_block = has_byte && sts.fill_last;
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (phase_q == PH_MARK)
					cmd.sel = sha1md_pkg::SEL_MARK;
				else if (phase_q == PH_LEN || sts.fill_len)
					cmd.sel = sha1md_pkg::SEL_LEN;
				else
					cmd.sel = sha1md_pkg::SEL_ZERO;
				cmd.start_block = sts.fill_last;
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_ADD:   cmd.add = 1'b1;
			ST_DONE:  cmd.finish = !sts.out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MARK;
			last_q <= 1'b0;
			padding_q <= 1'b0;
			round_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last;
						round_q <= '0;
						if (has_byte && sts.fill_last)
							state_q <= ST_ROUND;
						else if (last) begin
							state_q <= ST_PAD;
							phase_q <= PH_MARK;
							padding_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					if (phase_q == PH_MARK)
						phase_q <= PH_ZERO;
					else if (phase_q == PH_ZERO && sts.fill_len)
						phase_q <= PH_LEN;
					round_q <= '0;
					if (sts.fill_last)
						state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == sha1md_pkg::CNT_W'(sha1md_pkg::ROUNDS - 1))
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (padding_q) begin
						if (phase_q == PH_LEN)
							state_q <= ST_DONE;
						else
							state_q <= ST_PAD;
					end else if (last_q) begin
						state_q <= ST_PAD;
						phase_q <= PH_MARK;
						padding_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
						padding_q <= 1'b0;
						last_q <= 1'b0;
						phase_q <= PH_MARK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q < sha1md_pkg::CNT_W'(sha1md_pkg::ROUNDS)))
		else $error("round counter out of range");

	a_start_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_block |-> (cmd.push && sts.fill_last))
		else $error("block started before buffer full");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE && !padding_q))
		else $error("no return to idle after digest");

endmodule

@@ rtl/sha1md_dp.sv @@
// datapath for the sha-1 message digest block: block buffer and message
// schedule, round logic, chaining value, bit count, digest output register
// depends on sha1md_pkg
module sha1md_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_byte,
	input  sha1md_pkg::cmd_t cmd,
	output sha1md_pkg::sts_t sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	logic [511:0]                      buf_q;
	logic [sha1md_pkg::FILL_W-1:0]     fill_q;
	logic [63:0]                       bit_count_q;
	logic [31:0]                       h0_q, h1_q, h2_q, h3_q, h4_q;
	logic [31:0]                       a_q, b_q, c_q, d_q, e_q;
	logic [159:0]                      out_q;
	logic [2:0]                        out_cnt_q;
	logic                              out_valid_q;

	logic [7:0]  push_byte;
	logic [2:0]  len_idx;
	logic [31:0] w0, w2, w8, w13, w_new, f, k, t;

	assign len_idx = 3'd7 - fill_q[2:0];

	always_comb begin
		case (cmd.sel)
			sha1md_pkg::SEL_DATA: push_byte = data_byte;
			sha1md_pkg::SEL_MARK: push_byte = sha1md_pkg::PAD_MARK;
			sha1md_pkg::SEL_ZERO: push_byte = 8'h00;
			default:              push_byte = bit_count_q[{len_idx, 3'b000} +: 8];
		endcase
	end

	// schedule taps, word 0 is the oldest
	assign w0  = buf_q[511:480];
	assign w2  = buf_q[447:416];
	assign w8  = buf_q[255:224];
	assign w13 = buf_q[95:64];
	assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
		(w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

	always_comb begin
		case (cmd.grp)
			sha1md_pkg::GRP_CH: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = sha1md_pkg::K0;
			end
			sha1md_pkg::GRP_P1: begin
				f = b_q ^ c_q ^ d_q;
				k = sha1md_pkg::K1;
			end
			sha1md_pkg::GRP_MAJ: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = sha1md_pkg::K2;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = sha1md_pkg::K3;
			end
		endcase
	end

	assign t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;

	always_ff @(posedge clk) begin
		if (cmd.push)
			buf_q <= {buf_q[503:0], push_byte};
		else if (cmd.round)
			buf_q <= {buf_q[479:0], w_new};
		if (cmd.start_block) begin
			a_q <= h0_q;
			b_q <= h1_q;
			c_q <= h2_q;
			d_q <= h3_q;
			e_q <= h4_q;
		end else if (cmd.round) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.finish)
			out_q <= {h0_q, h1_q, h2_q, h3_q, h4_q};
		else if (out_valid_q && out_ready)
			out_q <= {out_q[127:0], 32'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bit_count_q <= '0;
			h0_q <= sha1md_pkg::IV0;
			h1_q <= sha1md_pkg::IV1;
			h2_q <= sha1md_pkg::IV2;
			h3_q <= sha1md_pkg::IV3;
			h4_q <= sha1md_pkg::IV4;
			out_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				fill_q <= '0;
				bit_count_q <= '0;
				h0_q <= sha1md_pkg::IV0;
				h1_q <= sha1md_pkg::IV1;
				h2_q <= sha1md_pkg::IV2;
				h3_q <= sha1md_pkg::IV3;
				h4_q <= sha1md_pkg::IV4;
				out_cnt_q <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (cmd.push)
					fill_q <= fill_q + 1'b1;
				if (cmd.count)
					bit_count_q <= bit_count_q + 64'd8;
				if (cmd.add) begin
					h0_q <= h0_q + a_q;
					h1_q <= h1_q + b_q;
					h2_q <= h2_q + c_q;
					h3_q <= h3_q + d_q;
					h4_q <= h4_q + e_q;
				end
				if (out_valid_q && out_ready) begin
					out_cnt_q <= out_cnt_q + 1'b1;
					if (out_cnt_q == 3'(sha1md_pkg::WORDS - 1))
						out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign sts.fill_last = (fill_q == '1);
	assign sts.fill_len  = (fill_q == sha1md_pkg::LEN_POS);
	assign sts.out_busy  = out_valid_q;

	assign out_valid   = out_valid_q;
	assign digest_word = out_q[159:128];
	assign word_index  = out_cnt_q;
	assign last_word   = (out_cnt_q == 3'(sha1md_pkg::WORDS - 1));

	a_out_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_cnt_q <= 3'(sha1md_pkg::WORDS - 1)))
		else $error("digest word index out of range");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q)
		else $error("digest loaded over pending words");

	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (fill_q == '0 && bit_count_q == '0 && out_cnt_q == '0))
		else $error("message state not cleared after digest");

endmodule

@@ verif/sha1md_checker.sv @@
`timescale 1ns / 1ps
// scoreboard for the sha-1 message digest block: follows both transfers,
// keeps its own sha-1 state and compares every digest word; no dependencies
module sha1md_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        fin;
	} digest_word_t;

	logic [31:0]  hash_h [5];
	logic [7:0]   msg_block [64];
	logic [5:0]   block_fill;
	logic [63:0]  msg_bits;
	digest_word_t digest_q [$];
	digest_word_t want;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic reset_hash();
		hash_h[0] = 32'h67452301;
		hash_h[1] = 32'hEFCDAB89;
		hash_h[2] = 32'h98BADCFE;
		hash_h[3] = 32'h10325476;
		hash_h[4] = 32'hC3D2E1F0;
		block_fill = '0;
		msg_bits = '0;
	endtask

	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_h[0];
		b = hash_h[1];
		c = hash_h[2];
		d = hash_h[3];
		e = hash_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_h[0] = hash_h[0] + a;
		hash_h[1] = hash_h[1] + b;
		hash_h[2] = hash_h[2] + c;
		hash_h[3] = hash_h[3] + d;
		hash_h[4] = hash_h[4] + e;
	endtask

	task automatic absorb_byte(input logic [7:0] v);
		msg_block[block_fill] = v;
		if (block_fill == 6'd63) begin
			sha1_compress();
			block_fill = '0;
		end else begin
			block_fill = block_fill + 6'd1;
		end
	endtask

	// pad, append the bit length and queue the five digest words
	task automatic close_message();
		logic [63:0]  len;
		digest_word_t dw;
		len = msg_bits;
		absorb_byte(8'h80);
		while (block_fill != 6'd56)
			absorb_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			absorb_byte(len[8*i +: 8]);
		for (int i = 0; i < 5; i++) begin
			dw.word = hash_h[i];
			dw.index = 3'(i);
			dw.fin = (i == 4);
			digest_q = {digest_q, dw};
		end
		reset_hash();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			digest_q.delete();
			reset_hash();
		end else begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest word, expected none, got %h index %0d",
						$time, digest_word, word_index);
				end else begin
					want = digest_q.pop_front();
					if (digest_word !== want.word) begin
						errors++;
						$display("%0t: digest_word expected %h got %h",
							$time, want.word, digest_word);
					end
					if (word_index !== want.index) begin
						errors++;
						$display("%0t: word_index expected %0d got %0d",
							$time, want.index, word_index);
					end
					if (last_word !== want.fin) begin
						errors++;
						$display("%0t: last_word expected %b got %b",
							$time, want.fin, last_word);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (has_byte) begin
					absorb_byte(data_byte);
					msg_bits = msg_bits + 64'd8;
				end
				if (last)
					close_message();
			end
			pending = digest_q.size();
		end
	end

endmodule

@@ verif/tb_sha1_message_digest.sv @@
`timescale 1ns / 1ps
// testbench top for sha1_message_digest: clock, reset, message stimulus and verdict
// depends on the block under test and on sha1md_checker for all checking
module tb_sha1_message_digest;

	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int MIN_ITEMS    = 150;
	localparam int MIN_MESSAGES = 10;
	localparam int TIMEOUT_NS   = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          errors;
	int          pending;
	int          item_count;
	int          msg_count;
	bit          calm;
	bit          hold_now;

	sha1_message_digest u_top (.*);

	sha1md_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= hb;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (hb || lst)
			item_count++;
		if (lst)
			msg_count++;
	endtask

	// random bytes, stray empty transfers, last either on the final byte or on its own
	task automatic send_message(input int len);
		bit last_on_byte;
		last_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, last_on_byte && (i == len - 1));
		end
		if (!last_on_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// mostly short messages, some around the padding and block boundaries
	function automatic int pick_length();
		int boundary [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 15)
			return $urandom_range(0, 12);
		if (sel < 19)
			return boundary[$urandom_range(0, 9)];
		return $urandom_range(66, 130);
	endfunction

	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_now && !held) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held = 1'b1;
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		has_byte = 1'b0;
		last = 1'b0;
		item_count = 0;
		msg_count = 0;
		calm = 1'b0;
		hold_now = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// length wrap needs 2^61 bytes and is not reached here
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);

		hold_now = 1'b1;
		while (item_count < MIN_ITEMS || msg_count < MIN_MESSAGES)
			send_message(pick_length());
		calm = 1'b1;
		repeat (2) send_message(pick_length());
		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
